@@ rtl/ddsm_pkg.sv @@
// ----------------------------------------------------------------------------
// ddsm_pkg
// Shared types and constants of the distinct-destination slow monitor.
// ----------------------------------------------------------------------------
package ddsm_pkg;

    localparam int unsigned ADDR_W = 32;
    localparam int unsigned TICK_W = 32;
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    // Reset lengths of the two windows, in ticks
    localparam logic [TICK_W-1:0] SHORT_TICKS_RESET = 32'd180;
    localparam logic [TICK_W-1:0] LONG_TICKS_RESET  = 32'd3600;

    // Request kinds
    localparam logic REQ_REPORT = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_LISTENER   = 2'd0;
    localparam logic [1:0] REG_SHORT_LEN  = 2'd1;
    localparam logic [1:0] REG_LONG_LEN   = 2'd2;

    // Commands from the item stage to the window timer
    typedef struct packed {
        logic tick;
        logic event_hit;
        logic any_full;
    } ddsm_win_cmd_t;

    // Window timer status back to the item stage and the table
    typedef struct packed {
        logic long_window;
        logic clear_table;
    } ddsm_win_stat_t;

endpackage

@@ rtl/ddsm_table.sv @@
// ----------------------------------------------------------------------------
// ddsm_table
// Source slot table with per-source distinct destination lists.
// ----------------------------------------------------------------------------
module ddsm_table #(
    parameter int unsigned SRC_SLOTS = 2,
    parameter int unsigned DST_SLOTS = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       report_en,
    input  logic                       clear_table,
    input  logic [ddsm_pkg::ADDR_W-1:0] req_src,
    input  logic [ddsm_pkg::ADDR_W-1:0] req_dst,
    output logic                       slot_full,
    output logic                       any_full
);
    import ddsm_pkg::*;

    localparam int unsigned CNT_W = $clog2(DST_SLOTS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DST_SLOTS);

    logic [ADDR_W-1:0] src_slot_reg [SRC_SLOTS];
    logic [CNT_W-1:0]  dst_cnt_reg  [SRC_SLOTS];
    logic [ADDR_W-1:0] dst_slot_reg [SRC_SLOTS][DST_SLOTS];

    logic [SRC_SLOTS-1:0] first_hit;
    logic                 found;
    logic [CNT_W-1:0]     cnt_sel;
    logic                 dup_sel;
    logic                 add_dst;
    logic [CNT_W-1:0]     cnt_new;

    // Pick the first slot that is empty or already holds this source
    always_comb
    begin
        logic taken;
        taken     = 1'b0;
        first_hit = '0;
        for (int i = 0; i < SRC_SLOTS; i++)
        begin
            if (!taken && (src_slot_reg[i] == '0 || src_slot_reg[i] == req_src))
            begin
                first_hit[i] = 1'b1;
                taken        = 1'b1;
            end
        end
        found = taken;
    end

    // Selected count and duplicate check over the selected slot, and a full flag over all slots
    always_comb
    begin
        cnt_sel = '0;
        dup_sel = 1'b0;
        any_full = 1'b0;
        for (int i = 0; i < SRC_SLOTS; i++)
        begin
            if (first_hit[i])
            begin
                cnt_sel = cnt_sel | dst_cnt_reg[i];
            end
            if (dst_cnt_reg[i] == CNT_FULL)
            begin
                any_full = 1'b1;
            end
            for (int j = 0; j < DST_SLOTS; j++)
            begin
                if (first_hit[i] && (CNT_W'(j) < dst_cnt_reg[i])
                    && dst_slot_reg[i][j] == req_dst)
                begin
                    dup_sel = 1'b1;
                end
            end
        end
        add_dst   = (cnt_sel < CNT_FULL) && !dup_sel;
        cnt_new   = add_dst ? cnt_sel + CNT_W'(1) : cnt_sel;
        slot_full = found && (cnt_new == CNT_FULL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SRC_SLOTS; i++)
            begin
                src_slot_reg[i] <= '0;
                dst_cnt_reg[i]  <= '0;
            end
        end
        else if (clear_table)
        begin
            for (int i = 0; i < SRC_SLOTS; i++)
            begin
                src_slot_reg[i] <= '0;
                dst_cnt_reg[i]  <= '0;
            end
        end
        else if (report_en)
        begin
            for (int i = 0; i < SRC_SLOTS; i++)
            begin
                if (first_hit[i])
                begin
                    src_slot_reg[i] <= req_src;
                    dst_cnt_reg[i]  <= cnt_new;
                end
            end
        end
    end

    // Destination entries carry no reset; only entries below the count are read
    always_ff @(posedge clk)
    begin
        if (report_en && !clear_table && add_dst)
        begin
            for (int i = 0; i < SRC_SLOTS; i++)
            begin
                for (int j = 0; j < DST_SLOTS; j++)
                begin
                    if (first_hit[i] && cnt_sel == CNT_W'(j))
                    begin
                        dst_slot_reg[i][j] <= req_dst;
                    end
                end
            end
        end
    end

endmodule

@@ rtl/ddsm_window.sv @@
// ----------------------------------------------------------------------------
// ddsm_window
// Short/long window state and tick countdown.
// ----------------------------------------------------------------------------
module ddsm_window (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ddsm_pkg::ddsm_win_cmd_t    cmd,
    input  logic [ddsm_pkg::TICK_W-1:0] short_len,
    input  logic [ddsm_pkg::TICK_W-1:0] long_len,
    output ddsm_pkg::ddsm_win_stat_t   stat
);
    import ddsm_pkg::*;

    logic              long_window_reg;
    logic              long_window_next;
    logic [TICK_W-1:0] ticks_left_reg;
    logic [TICK_W-1:0] ticks_left_next;
    logic              expire;

    always_comb
    begin
        long_window_next = long_window_reg;
        ticks_left_next  = ticks_left_reg;
        stat.clear_table = 1'b0;
        expire           = ticks_left_reg <= TICK_W'(1);
        if (cmd.tick)
        begin
            if (!expire)
            begin
                ticks_left_next = ticks_left_reg - TICK_W'(1);
            end
            else if (long_window_reg || !cmd.any_full)
            begin
                // back to a fresh short window
                stat.clear_table = 1'b1;
                long_window_next = 1'b0;
                ticks_left_next  = short_len;
            end
            else
            begin
                long_window_next = 1'b1;
                ticks_left_next  = long_len;
            end
        end
        else if (cmd.event_hit)
        begin
            long_window_next = 1'b1;
            ticks_left_next  = long_len;
        end
        stat.long_window = long_window_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_window_reg <= 1'b0;
            ticks_left_reg  <= SHORT_TICKS_RESET;
        end
        else
        begin
            long_window_reg <= long_window_next;
            ticks_left_reg  <= ticks_left_next;
        end
    end

endmodule

@@ rtl/distinct_destination_slow_monitor_unit.sv @@
// ----------------------------------------------------------------------------
// distinct_destination_slow_monitor_unit
// Flags a source address that reaches a set number of distinct slow
// destinations inside the short observation window.
// ----------------------------------------------------------------------------
// Path: an accepted transfer is held in the input register, then its event is
//   loaded into the result register; the transfer waits in the input register
//   while the output side stalls with an earlier event not yet taken.
// Throughput: one transfer per cycle; the table update and the countdown are
//   each one pass of logic between the input register and the result register.
//   An event left waiting holds the input register and drops in_ready.
// Reset: rst_n clears the source table, counts and window state and loads the
//   short window with 180 ticks; destination entries are not cleared.
// ----------------------------------------------------------------------------
module distinct_destination_slow_monitor_unit #(
    parameter int unsigned SRC_SLOTS = 2,
    parameter int unsigned DST_SLOTS = 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ddsm_pkg::PADDR_W-1:0] paddr,
    input  logic [ddsm_pkg::PDATA_W-1:0] pwdata,
    output logic [ddsm_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    // request channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic [ddsm_pkg::ADDR_W-1:0]  req_src,
    input  logic [ddsm_pkg::ADDR_W-1:0]  req_dst,
    // event channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ddsm_pkg::ADDR_W-1:0]  event_source
);
    import ddsm_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic              listener_reg;
    logic [TICK_W-1:0] short_len_reg;
    logic [TICK_W-1:0] long_len_reg;
    logic              cfg_wr;
    logic [1:0]        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            listener_reg  <= 1'b0;
            short_len_reg <= SHORT_TICKS_RESET;
            long_len_reg  <= LONG_TICKS_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_LISTENER:  listener_reg  <= pwdata[0];
                REG_SHORT_LEN: short_len_reg <= pwdata;
                REG_LONG_LEN:  long_len_reg  <= pwdata;
                default:       ;
            endcase
        end
    end

    // Read back the addressed register; unused addresses read zero
    always_comb
    begin
        unique case (cfg_idx)
            REG_LISTENER:  prdata = {{(PDATA_W-1){1'b0}}, listener_reg};
            REG_SHORT_LEN: prdata = short_len_reg;
            REG_LONG_LEN:  prdata = long_len_reg;
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register: hold one transfer until the item stage runs it
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    logic              s1_type_reg;
    logic [ADDR_W-1:0] s1_src_reg;
    logic [ADDR_W-1:0] s1_dst_reg;
    logic              s1_fire;

    // The item stage runs whenever the result register is free or draining
    assign s1_fire  = s1_valid_reg && (!out_valid || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_type_reg <= req_type;
            s1_src_reg  <= req_src;
            s1_dst_reg  <= req_dst;
        end
    end

    // ------------------------------------------------------------------
    // Item stage: table lookup and window control
    // ------------------------------------------------------------------
    ddsm_win_cmd_t  win_cmd;
    ddsm_win_stat_t win_stat;
    logic           report_en;
    logic           slot_full;
    logic           any_full;

    // Drop reports in the long window or with no listener registered
    assign report_en = s1_fire && (s1_type_reg == REQ_REPORT)
                       && !win_stat.long_window && listener_reg;

    assign win_cmd.tick      = s1_fire && (s1_type_reg == REQ_TICK);
    assign win_cmd.event_hit = report_en && slot_full;
    assign win_cmd.any_full  = any_full;

    ddsm_table #(
        .SRC_SLOTS (SRC_SLOTS),
        .DST_SLOTS (DST_SLOTS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .report_en   (report_en),
        .clear_table (win_stat.clear_table),
        .req_src     (s1_src_reg),
        .req_dst     (s1_dst_reg),
        .slot_full   (slot_full),
        .any_full    (any_full)
    );

    ddsm_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (win_cmd),
        .short_len (short_len_reg),
        .long_len  (long_len_reg),
        .stat      (win_stat)
    );

    // ------------------------------------------------------------------
    // Result register: hold the event until the transfer completes
    // ------------------------------------------------------------------
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ADDR_W-1:0] event_src_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (win_cmd.event_hit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The matched or newly claimed slot always holds the report's source
    always_ff @(posedge clk)
    begin
        if (win_cmd.event_hit)
        begin
            event_src_reg <= s1_src_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_source = event_src_reg;

endmodule

@@ sim/distinct_destination_slow_monitor_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// distinct_destination_slow_monitor_unit_tb
// Self-checking bench for the distinct-destination slow monitor. A directed
// table covers the corner cases, then random phases run under several window
// and listener settings. Reports come from small address pools so sources
// really fill up their destination slots. A cycle-free model in the bench
// tracks the table and the window timer, and every event transfer is checked
// in order. Both handshakes see random gaps, stalls and steady stretches.
// ----------------------------------------------------------------------------
module distinct_destination_slow_monitor_unit_tb;

    import ddsm_pkg::*;

    localparam int SRC_SLOTS     = 2;
    localparam int DST_SLOTS     = 3;
    localparam int SETTLE_CYCLES = 8;   // pipeline is two stages deep; add margin
    localparam int NUM_PHASES    = 8;

    // How a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,   // compare against the bench model
        CHK_NONE,    // no event may come from this transfer
        CHK_EVENT    // exactly the listed source must be reported
    } row_check_t;

    typedef struct packed {
        logic              is_cfg;
        logic [1:0]        reg_idx;
        logic [31:0]       wdata;
        logic              rtype;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        row_check_t        chk;
        logic [ADDR_W-1:0] exp_src;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic               req_type;
    logic [ADDR_W-1:0]  req_src;
    logic [ADDR_W-1:0]  req_dst;
    logic               out_valid;
    logic               out_ready = 1'b1;
    logic [ADDR_W-1:0]  event_source;

    distinct_destination_slow_monitor_unit #(
        .SRC_SLOTS (SRC_SLOTS),
        .DST_SLOTS (DST_SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .req_src      (req_src),
        .req_dst      (req_dst),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_source (event_source)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Monitor model: configuration, window timer and source table
    // ------------------------------------------------------------------------
    logic              cfg_listener = 1'b0;
    logic [TICK_W-1:0] cfg_short    = SHORT_TICKS_RESET;
    logic [TICK_W-1:0] cfg_long     = LONG_TICKS_RESET;

    logic              win_long     = 1'b0;
    logic [TICK_W-1:0] win_left     = SHORT_TICKS_RESET;
    logic [ADDR_W-1:0] src_tab [SRC_SLOTS];
    logic [ADDR_W-1:0] dst_tab [SRC_SLOTS*DST_SLOTS];
    logic [1:0]        dst_cnt [SRC_SLOTS];

    // Sources the DUT still owes us, oldest first
    logic [ADDR_W-1:0] pending_events [$];
    int                fail_count = 0;

    initial
    begin
        foreach (src_tab[k])
        begin
            src_tab[k] = '0;
            dst_cnt[k] = '0;
        end
    end

    // Clearing drops sources and counts; destination entries are left alone
    function automatic void table_clear();
        foreach (src_tab[k])
        begin
            src_tab[k] = '0;
            dst_cnt[k] = '0;
        end
    endfunction

    // Reload the countdown from the register of the window being opened
    function automatic void window_open(input logic long_w);
        win_long = long_w;
        win_left = long_w ? cfg_long : cfg_short;
    endfunction

    // Advance the model by one transfer; hit/who carry the event it raises, if any.
    function automatic void monitor_predict(input logic t, input logic [ADDR_W-1:0] s,
                                            input logic [ADDR_W-1:0] d,
                                            output bit hit, output logic [ADDR_W-1:0] who);
        int slot;
        bit any_full;
        bit dup;
        hit = 1'b0;
        who = '0;
        if (t == REQ_TICK)
        begin
            // expire on a count of 1, and on 0 (zero length acts like one)
            if (win_left > 1)
            begin
                win_left = win_left - 1;
                return;
            end
            if (win_long)
            begin
                table_clear();
                window_open(1'b0);
                return;
            end
            any_full = 1'b0;
            foreach (dst_cnt[k])
                if (dst_cnt[k] == DST_SLOTS)
                    any_full = 1'b1;
            if (any_full)
            begin
                window_open(1'b1);
            end
            else
            begin
                table_clear();
                window_open(1'b0);
            end
            return;
        end
        if (win_long || !cfg_listener)
            return;
        // the first slot that is empty or holds this source wins;
        // a zero source writes zero back, so its slot stays free
        slot = -1;
        for (int k = 0; k < SRC_SLOTS; k++)
        begin
            if (slot < 0)
            begin
                if (src_tab[k] == '0)
                begin
                    src_tab[k] = s;
                    slot = k;
                end
                else if (src_tab[k] == s)
                begin
                    slot = k;
                end
            end
        end
        if (slot < 0)
            return;
        if (dst_cnt[slot] < DST_SLOTS)
        begin
            dup = 1'b0;
            for (int j = 0; j < dst_cnt[slot]; j++)
                if (dst_tab[slot*DST_SLOTS + j] == d)
                    dup = 1'b1;
            if (!dup)
            begin
                dst_tab[slot*DST_SLOTS + dst_cnt[slot]] = d;
                dst_cnt[slot] = dst_cnt[slot] + 2'd1;
            end
        end
        if (dst_cnt[slot] == DST_SLOTS)
        begin
            window_open(1'b1);
            hit = 1'b1;
            who = src_tab[slot];
        end
    endfunction

    // ------------------------------------------------------------------------
    // Idle shaping: mostly short gaps, a few long ones
    // ------------------------------------------------------------------------
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    int rx_hold   = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Event side: drive ready at the falling edge, with stall bursts
    always @(negedge clk)
    begin
        if ($urandom_range(0, 40) == 0)
            rx_steady <= !rx_steady;
        if (rx_steady)
        begin
            out_ready <= 1'b1;
        end
        else if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                rx_hold <= gap_len();
        end
    end

    // Check every event transfer against the oldest expectation
    logic [ADDR_W-1:0] want_src;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_events.size() == 0)
            begin
                $error("event_source: expected none, got %h", event_source);
                fail_count++;
            end
            else
            begin
                want_src = pending_events.pop_front();
                if (event_source !== want_src)
                begin
                    $error("event_source: expected %h, got %h", want_src, event_source);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side and configuration port
    // ------------------------------------------------------------------------

    // Present one transfer and hold it until accepted. Call at a falling edge;
    // returns at the falling edge after the transfer. With hold set, drop
    // valid and wait until every owed event has come out first.
    task automatic send_transfer(input logic t, input logic [ADDR_W-1:0] s,
                                 input logic [ADDR_W-1:0] d, input bit hold,
                                 input row_check_t chk, input logic [ADDR_W-1:0] exp_src);
        int gap;
        bit hit;
        logic [ADDR_W-1:0] who;
        if ($urandom_range(0, 40) == 0)
            tx_steady = !tx_steady;
        gap = (hold || tx_steady) ? 0 : gap_len();
        if (hold)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while (pending_events.size() != 0)
                @(negedge clk);
        end
        else if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= t;
        req_src  <= s;
        req_dst  <= d;
        do
            @(posedge clk);
        while (!in_ready);
        monitor_predict(t, s, d, hit, who);
        case (chk)
            CHK_MODEL: if (hit) pending_events.push_back(who);
            CHK_EVENT: pending_events.push_back(exp_src);
            default:   ;
        endcase
        @(negedge clk);
    endtask

    // Drop valid, let owed events drain, then give reports that raise no
    // event time to leave the pipeline before touching registers
    task automatic settle_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write one register, then read it back. Call at a falling edge.
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_LISTENER:  cfg_listener = val[0];
            REG_SHORT_LEN: cfg_short    = val;
            REG_LONG_LEN:  cfg_long     = val;
            default:       ;
        endcase
        want = (idx == REG_LISTENER) ? {31'd0, val[0]} : val;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            $error("prdata: expected %h, got %h", want, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic stim_row_t item_row(input logic t, input logic [ADDR_W-1:0] s,
                                           input logic [ADDR_W-1:0] d, input row_check_t chk,
                                           input logic [ADDR_W-1:0] exp_src);
        stim_row_t r;
        r = '0;
        r.rtype   = t;
        r.src     = s;
        r.dst     = d;
        r.chk     = chk;
        r.exp_src = exp_src;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [1:0] idx, input logic [31:0] val);
        stim_row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.wdata   = val;
        r.chk     = CHK_NONE;
        return r;
    endfunction

    // Random address with the all-zero and all-one corners mixed in
    function automatic logic [ADDR_W-1:0] pick_addr();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // Settings of each random phase; the huge long window comes last since
    // nothing brings the block back from it within the run
    task automatic phase_plan(input int p, output logic lis, output logic [31:0] sh,
                              output logic [31:0] lg, output int n);
        case (p)
            0: begin lis = 1'b1; sh = 32'd4;        lg = 32'd3;        n = 110; end
            1: begin lis = 1'b1; sh = 32'd0;        lg = 32'd0;        n = 80;  end
            2: begin lis = 1'b0; sh = 32'd2;        lg = 32'd2;        n = 30;  end
            3: begin lis = 1'b1; sh = 32'd1;        lg = 32'd1;        n = 100; end
            4: begin lis = 1'b1; sh = 32'hFFFFFFFF; lg = 32'd2;        n = 100; end
            5: begin lis = 1'b1; sh = 32'd8;        lg = 32'd5;        n = 140; end
            6:
            begin
                lis = 1'b1;
                sh  = $urandom_range(0, 12);
                lg  = $urandom_range(0, 10);
                n   = 130;
            end
            default: begin lis = 1'b1; sh = 32'd3; lg = 32'hFFFFFFFF; n = 60; end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        stim_row_t         rows [$];
        logic [ADDR_W-1:0] src_pool [3];
        logic [ADDR_W-1:0] dst_pool [5];
        logic              lis;
        logic [31:0]       sh;
        logic [31:0]       lg;
        int                target;
        int                sent;
        int                r;
        bit                hold;
        logic              t;
        logic [ADDR_W-1:0] s;
        logic [ADDR_W-1:0] d;

        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        req_type = REQ_REPORT;
        req_src  = '0;
        req_dst  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table. Reset state: no listener, short window of 180.
        // no listener yet: report is dropped
        rows.push_back(item_row(REQ_REPORT, 32'h0A000001, 32'h00000001, CHK_NONE, '0));
        rows.push_back(cfg_row(REG_LISTENER, 32'd1));
        rows.push_back(cfg_row(REG_LONG_LEN, 32'd2));
        rows.push_back(cfg_row(REG_SHORT_LEN, 32'd3));
        // all-ones source reports three destinations, one repeated
        rows.push_back(item_row(REQ_REPORT, 32'hFFFFFFFF, 32'h00000000, CHK_NONE, '0));
        rows.push_back(item_row(REQ_REPORT, 32'hFFFFFFFF, 32'h00000000, CHK_NONE, '0));
        rows.push_back(item_row(REQ_REPORT, 32'hFFFFFFFF, 32'hFFFFFFFF, CHK_NONE, '0));
        rows.push_back(item_row(REQ_REPORT, 32'h00000001, 32'h00000001, CHK_NONE, '0));
        // table full: a third source is dropped
        rows.push_back(item_row(REQ_REPORT, 32'h80000000, 32'h00000005, CHK_NONE, '0));
        rows.push_back(item_row(REQ_REPORT, 32'hFFFFFFFF, 32'h12345678, CHK_EVENT,
                                32'hFFFFFFFF));
        // long window: reports dropped until two ticks pass
        rows.push_back(item_row(REQ_REPORT, 32'h00000001, 32'h00000002, CHK_NONE, '0));
        rows.push_back(item_row(REQ_TICK, '0, '0, CHK_MODEL, '0));
        rows.push_back(item_row(REQ_TICK, '1, '1, CHK_MODEL, '0));
        // zero source fills a slot it never owns; the next source inherits it
        rows.push_back(item_row(REQ_REPORT, 32'h00000000, 32'h00000007, CHK_NONE, '0));
        rows.push_back(item_row(REQ_REPORT, 32'h00000000, 32'h00000008, CHK_NONE, '0));
        rows.push_back(item_row(REQ_REPORT, 32'h5555AAAA, 32'h00000009, CHK_EVENT,
                                32'h5555AAAA));
        rows.push_back(item_row(REQ_TICK, '0, '0, CHK_NONE, '0));
        rows.push_back(item_row(REQ_TICK, '0, '0, CHK_NONE, '0));
        // zero source alone reaches the limit and is reported as zero
        rows.push_back(item_row(REQ_REPORT, 32'h00000000, 32'h00000001, CHK_NONE, '0));
        rows.push_back(item_row(REQ_REPORT, 32'h00000000, 32'h00000002, CHK_NONE, '0));
        rows.push_back(item_row(REQ_REPORT, 32'h00000000, 32'h00000003, CHK_EVENT, '0));
        rows.push_back(item_row(REQ_TICK, '0, '0, CHK_NONE, '0));
        rows.push_back(item_row(REQ_TICK, '0, '0, CHK_NONE, '0));
        // short window runs out with no full slot: table is cleared
        rows.push_back(item_row(REQ_REPORT, 32'h0000FFFF, 32'h00000001, CHK_NONE, '0));
        rows.push_back(item_row(REQ_TICK, '0, '0, CHK_NONE, '0));
        rows.push_back(item_row(REQ_TICK, '0, '0, CHK_NONE, '0));
        rows.push_back(item_row(REQ_TICK, '0, '0, CHK_NONE, '0));
        rows.push_back(item_row(REQ_REPORT, 32'h0000FFFF, 32'h00000002, CHK_MODEL, '0));

        foreach (rows[i])
        begin
            if (rows[i].is_cfg)
            begin
                settle_idle();
                reg_write(rows[i].reg_idx, rows[i].wdata);
            end
            else
            begin
                send_transfer(rows[i].rtype, rows[i].src, rows[i].dst, 1'b0,
                              rows[i].chk, rows[i].exp_src);
            end
        end

        // Random phases: reports from small pools so slots fill, some ticks,
        // and some noise with fresh addresses
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            phase_plan(p, lis, sh, lg, target);
            settle_idle();
            reg_write(REG_LISTENER, {31'd0, lis});
            reg_write(REG_SHORT_LEN, sh);
            reg_write(REG_LONG_LEN, lg);
            foreach (src_pool[k])
                src_pool[k] = pick_addr();
            foreach (dst_pool[k])
                dst_pool[k] = pick_addr();
            sent = 0;
            while (sent < target)
            begin
                r = $urandom_range(0, 99);
                t = REQ_REPORT;
                s = src_pool[$urandom_range(0, 2)];
                d = dst_pool[$urandom_range(0, 4)];
                if (r < 22)
                begin
                    t = REQ_TICK;
                    s = $urandom;
                    d = $urandom;
                end
                else if (r >= 94)
                begin
                    d = $urandom;
                end
                else if (r >= 88)
                begin
                    s = $urandom;
                    d = $urandom;
                end
                // sometimes hold off until the event side is empty
                hold = (sent == 40) || ($urandom_range(0, 60) == 0);
                send_transfer(t, s, d, hold, CHK_MODEL, '0);
                sent++;
            end
        end

        // Drain, then watch a little longer for stray events
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: well past the slowest legal run
    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ddsm_pkg.sv
rtl/ddsm_table.sv
rtl/ddsm_window.sv
rtl/distinct_destination_slow_monitor_unit.sv
sim/distinct_destination_slow_monitor_unit_tb.sv
